### src/mkpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkpm_pkg
// Shared types and codes for the multi-keyword prefix matcher: request and
// result payloads, the command passed from front to back, and state codes.
// ----------------------------------------------------------------------------
package mkpm_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_MATCH = 2'd2;

    localparam logic [1:0] STATUS_MATCHED   = 2'd0;
    localparam logic [1:0] STATUS_NO_MATCH  = 2'd1;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] byte_value;
        logic [4:0] keyword_index;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] keyword_id;
        logic [6:0] match_length;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_MARK,
        CMD_REFUSE,
        CMD_MATCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [6:0] position;
        logic [7:0] byte_value;
        logic [4:0] keyword_index;
        logic       last_byte;
        logic       fold;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_MARK_WR,
        ST_ALT_WR,
        ST_MATCH_EVAL,
        ST_REFUSE
    } back_state_t;

endpackage
`default_nettype wire

### src/mkpm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkpm_front
// Accepts requests, holds the case register and the keyword load position,
// and turns each request into a command for the back end or drops it.
// ----------------------------------------------------------------------------
module mkpm_front #(
    parameter int MAX_LEN      = 8,
    parameter int NUM_KEYWORDS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire mkpm_pkg::in_item_t in_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data,
    input  wire logic              init_done,
    output logic                   push_valid,
    output mkpm_pkg::cmd_t         push_data,
    input  wire logic              push_ready
);
    import mkpm_pkg::*;

    logic       case_sensitive_reg;
    logic [6:0] load_pos_reg, load_pos_next;
    logic       overflow_reg, overflow_next;
    logic       accept;
    logic       kw_in_range;
    logic       is_letter;

    assign cfg_ready = 1'b1;
    assign in_stall  = !init_done || !push_ready;
    assign accept    = in_valid && !in_stall;

    assign kw_in_range = {1'b0, in_data.keyword_index} < 6'(NUM_KEYWORDS);
    assign is_letter   = (in_data.byte_value >= 8'h61 && in_data.byte_value <= 8'h7a)
                      || (in_data.byte_value >= 8'h41 && in_data.byte_value <= 8'h5a);

    always_comb
    begin
        load_pos_next           = load_pos_reg;
        overflow_next           = overflow_reg;
        push_valid              = 1'b0;
        push_data.kind          = CMD_MATCH;
        push_data.position      = load_pos_reg;
        push_data.byte_value    = in_data.byte_value;
        push_data.keyword_index = in_data.keyword_index;
        push_data.last_byte     = in_data.last_byte;
        push_data.fold          = !case_sensitive_reg && is_letter;
        if (accept)
        begin
            case (in_data.operation)
                OP_CLEAR:
                begin
                    load_pos_next  = 7'd0;
                    overflow_next  = 1'b0;
                    push_valid     = 1'b1;
                    push_data.kind = CMD_CLEAR;
                end
                OP_LOAD:
                begin
                    if (kw_in_range)
                    begin
                        if (overflow_reg || load_pos_reg >= 7'(MAX_LEN))
                        begin
                            overflow_next = 1'b1;
                            if (in_data.last_byte)
                            begin
                                load_pos_next  = 7'd0;
                                overflow_next  = 1'b0;
                                push_valid     = 1'b1;
                                push_data.kind = CMD_REFUSE;
                            end
                        end
                        else
                        begin
                            push_valid     = 1'b1;
                            push_data.kind = CMD_MARK;
                            if (in_data.last_byte)
                            begin
                                load_pos_next = 7'd0;
                                overflow_next = 1'b0;
                            end
                            else
                            begin
                                load_pos_next = load_pos_reg + 7'd1;
                            end
                        end
                    end
                end
                OP_MATCH:
                begin
                    push_valid     = 1'b1;
                    push_data.kind = CMD_MATCH;
                end
                default:
                begin
                    push_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_sensitive_reg <= 1'b1;
            load_pos_reg       <= 7'd0;
            overflow_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case_sensitive_reg <= cfg_data;
            end
            load_pos_reg <= load_pos_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule
`default_nettype wire

### src/mkpm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkpm_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mkpm_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    input  wire mkpm_pkg::cmd_t push_data,
    output logic                push_ready,
    output logic                pop_valid,
    output mkpm_pkg::cmd_t      pop_data,
    input  wire logic           pop
);
    import mkpm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

### src/mkpm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mkpm_back
// Owns the keyword table memory and the match state; clears the table,
// merges keyword bits into it and evaluates subject bytes against it.
// ----------------------------------------------------------------------------
module mkpm_back #(
    parameter int MAX_LEN      = 8,
    parameter int NUM_KEYWORDS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire mkpm_pkg::cmd_t q_data,
    output logic                q_pop,
    output logic                init_done,
    output logic                out_valid,
    input  wire logic           out_stall,
    output mkpm_pkg::out_item_t out_data
);
    import mkpm_pkg::*;

    localparam int N     = NUM_KEYWORDS;
    localparam int PW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int AW    = PW + 8;
    localparam int DEPTH = MAX_LEN * 256;

    back_state_t  state_reg, state_next;
    cmd_t         cmd_reg;
    logic [AW-1:0] sweep_reg, sweep_next;

    logic [2*N-1:0] table_ram [DEPTH];
    logic [2*N-1:0] rd_data_reg;
    logic           mem_we, mem_re;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [2*N-1:0] mem_wdata;

    logic [N-1:0] alive_reg, alive_next;
    logic [N-1:0] ended_reg, ended_next;
    logic [6:0]   pos_reg, pos_next;
    logic [6:0]   best_reg, best_next;
    logic         decided_reg, decided_next;

    logic        out_valid_reg;
    out_item_t   out_data_reg, out_data_next;
    logic        emit, out_free;

    logic [N-1:0]   cur, ends, ended_eff, kw_bit;
    logic [6:0]     best_eff, pos_inc;
    logic [4:0]     head_idx, ended_idx;
    logic           pos_full, want_emit, finish, finish_best;
    logic [1:0]     fin_status, fail_status;
    logic [2*N-1:0] mark_bits;

    function automatic logic [AW-1:0] table_addr(input logic [6:0] pos, input logic [7:0] b);
        return {pos[PW-1:0], b};
    endfunction

    function automatic logic [4:0] lowest_index(input logic [N-1:0] v);
        logic [4:0] idx;
        idx = 5'd0;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                idx = 5'(k);
            end
        end
        return idx;
    endfunction

    assign init_done = state_reg != ST_INIT;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign kw_bit    = N'(1) << cmd_reg.keyword_index;
    assign mark_bits = {cmd_reg.last_byte ? kw_bit : '0, kw_bit};

    // match evaluation on the registered table entry
    assign pos_full  = pos_reg >= 7'(MAX_LEN);
    assign pos_inc   = pos_reg + 7'd1;
    assign cur       = alive_reg & rd_data_reg[N-1:0];
    assign ends      = rd_data_reg[2*N-1:N] & cur;
    assign head_idx  = lowest_index(cur);
    assign ended_eff = (!pos_full && cur != '0 && ends != '0) ? ends : ended_reg;
    assign best_eff  = (!pos_full && cur != '0 && ends != '0) ? pos_inc : best_reg;
    assign ended_idx = lowest_index(ended_eff);

    always_comb
    begin
        finish      = 1'b0;
        finish_best = 1'b0;
        fail_status = STATUS_TOO_SHORT;
        if (pos_full)
        begin
            finish_best = 1'b1;
        end
        else if (cur == '0)
        begin
            finish_best = 1'b1;
            fail_status = STATUS_NO_MATCH;
        end
        else if (ends != '0 && ends[head_idx])
        begin
            finish = 1'b1;
        end
        else if (cmd_reg.last_byte || pos_inc >= 7'(MAX_LEN))
        begin
            finish_best = 1'b1;
        end
        fin_status = (best_eff != 7'd0) ? STATUS_MATCHED : fail_status;
    end

    assign want_emit = (state_reg == ST_REFUSE)
                    || (state_reg == ST_MATCH_EVAL && !decided_reg && (finish || finish_best));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_data.kind)
                        CMD_CLEAR:  state_next = ST_CLEAR;
                        CMD_MARK:   state_next = ST_MARK_WR;
                        CMD_REFUSE: state_next = ST_REFUSE;
                        CMD_MATCH:  state_next = ST_MATCH_EVAL;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MARK_WR:
            begin
                state_next = cmd_reg.fold ? ST_ALT_WR : ST_IDLE;
            end
            ST_ALT_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_MATCH_EVAL, ST_REFUSE:
            begin
                if (!want_emit || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = table_addr(cmd_reg.position, cmd_reg.byte_value);
        mem_raddr     = table_addr(q_data.position, q_data.byte_value);
        mem_wdata     = rd_data_reg | mark_bits;
        sweep_next    = sweep_reg;
        alive_next    = alive_reg;
        ended_next    = ended_reg;
        pos_next      = pos_reg;
        best_next     = best_reg;
        decided_next  = decided_reg;
        emit          = 1'b0;
        out_data_next = out_data_reg;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '0;
                sweep_next = (sweep_reg == AW'(DEPTH - 1)) ? '0 : sweep_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop  = 1'b1;
                    mem_re = 1'b1;
                    if (q_data.kind == CMD_MATCH)
                    begin
                        mem_raddr = table_addr(pos_reg, q_data.byte_value);
                    end
                    if (q_data.kind == CMD_CLEAR)
                    begin
                        alive_next   = '1;
                        ended_next   = '0;
                        pos_next     = 7'd0;
                        best_next    = 7'd0;
                        decided_next = 1'b0;
                    end
                end
            end
            ST_MARK_WR:
            begin
                mem_we    = 1'b1;
                mem_re    = cmd_reg.fold;
                mem_raddr = table_addr(cmd_reg.position, cmd_reg.byte_value ^ 8'h20);
            end
            ST_ALT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = table_addr(cmd_reg.position, cmd_reg.byte_value ^ 8'h20);
            end
            ST_REFUSE:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_data_next = '{status: STATUS_TOO_LONG,
                                      keyword_id: cmd_reg.keyword_index,
                                      match_length: 7'd0};
                end
            end
            ST_MATCH_EVAL:
            begin
                if (decided_reg)
                begin
                    if (cmd_reg.last_byte)
                    begin
                        alive_next   = '1;
                        ended_next   = '0;
                        pos_next     = 7'd0;
                        best_next    = 7'd0;
                        decided_next = 1'b0;
                    end
                end
                else if (!want_emit || out_free)
                begin
                    if (!pos_full && cur != '0)
                    begin
                        ended_next = ended_eff;
                        best_next  = best_eff;
                        if (!finish)
                        begin
                            alive_next = cur;
                            pos_next   = pos_inc;
                        end
                    end
                    if (finish || finish_best)
                    begin
                        emit = 1'b1;
                        if (finish)
                        begin
                            out_data_next = '{status: STATUS_MATCHED, keyword_id: head_idx,
                                              match_length: pos_inc};
                        end
                        else if (fin_status == STATUS_MATCHED)
                        begin
                            out_data_next = '{status: STATUS_MATCHED, keyword_id: ended_idx,
                                              match_length: best_eff};
                        end
                        else
                        begin
                            out_data_next = '{status: fin_status, keyword_id: 5'd0,
                                              match_length: 7'd0};
                        end
                        if (cmd_reg.last_byte)
                        begin
                            alive_next   = '1;
                            ended_next   = '0;
                            pos_next     = 7'd0;
                            best_next    = 7'd0;
                            decided_next = 1'b0;
                        end
                        else
                        begin
                            decided_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_ram[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_ram[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
        if (emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            alive_reg     <= '1;
            ended_reg     <= '0;
            pos_reg       <= 7'd0;
            best_reg      <= 7'd0;
            decided_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            alive_reg   <= alive_next;
            ended_reg   <= ended_next;
            pos_reg     <= pos_next;
            best_reg    <= best_next;
            decided_reg <= decided_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### src/multi_keyword_prefix_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_keyword_prefix_matcher
// Bit-parallel table of up to NUM_KEYWORDS keywords of up to MAX_LEN bytes,
// with keyword load, table clear and subject byte matching.
// ----------------------------------------------------------------------------
// Requests enter a four-deep command queue, so the input side keeps flowing
// while the queue has room and the table engine works. The engine runs one
// command at a time against a table of 256*MAX_LEN entries with a registered
// read: a match byte is a read then an evaluation, a keyword byte a read then
// a write, plus a second write when case folding writes the other letter case
// too, a refused keyword one result. A clear request and the pass after reset
// sweep it at one entry a cycle; in_stall is high during the pass after reset.
module multi_keyword_prefix_matcher #(
    parameter int MAX_LEN      = 8,
    parameter int NUM_KEYWORDS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire mkpm_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output mkpm_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);
    import mkpm_pkg::*;

    cmd_t push_data, pop_data;
    logic push_valid, push_ready, pop_valid, pop;
    logic init_done;

    mkpm_front #(
        .MAX_LEN      (MAX_LEN),
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .init_done  (init_done),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    mkpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop        (pop)
    );

    mkpm_back #(
        .MAX_LEN      (MAX_LEN),
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_data    (pop_data),
        .q_pop     (pop),
        .init_done (init_done),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

### bench/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-keyword prefix matcher. Keyword sets are
// loaded phase by phase under both case modes, and subjects are then matched
// against them: mostly keyword-shaped text, plus prefixes, extensions, case
// flips, over-long keywords and stray requests. Each accepted request runs
// through a bit-accurate matcher model, and every returned result is checked
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import mkpm_pkg::*;

    localparam int MAX_LEN      = 8;
    localparam int TABLE_DEPTH  = MAX_LEN * 256;
    localparam int ITEMS        = 1400;
    localparam int DIRECTED     = 24;
    localparam int QUIET_CYCLES = 4 * TABLE_DEPTH + 64;

    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    typedef struct {
        in_item_t req;
        logic     drain_first;
    } queued_req_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    multi_keyword_prefix_matcher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // matcher model state
    logic [63:0] kw_table [0:TABLE_DEPTH-1];
    logic [31:0] alive;
    logic [31:0] ended;
    int          match_pos;
    int          best_len;
    logic        match_done;
    int          load_pos;
    logic        load_ovf;
    logic        cs_mode;

    out_item_t   expected_outcomes [$];
    queued_req_t request_queue [$];
    int          requests_left = 0;
    int          queued_total = 0;
    logic        hold_for_drain = 1'b0;
    int          error_count = 0;

    int          burst_left = 4;
    int          gap_left = 0;
    logic [6:0]  stall_tick = '0;

    logic [7:0]  kw_text [0:31][0:MAX_LEN+2];
    int          kw_len [0:31];
    int          loaded_ids [0:31];

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (error_count < 100)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int lowest_set(input logic [31:0] v);
        for (int k = 0; k < 32; k++)
            if (v[k])
                return k;
        return 0;
    endfunction

    task automatic restart_match();
        alive      = '1;
        ended      = '0;
        match_pos  = 0;
        best_len   = 0;
        match_done = 1'b0;
    endtask

    task automatic enter_byte(input int pos, input logic [7:0] b, input logic [63:0] bits);
        kw_table[pos * 256 + b] |= bits;
        if (!cs_mode)
        begin
            if (b >= CH_LOWER_A && b <= CH_LOWER_Z)
                kw_table[pos * 256 + (b - CASE_GAP)] |= bits;
            else if (b >= CH_UPPER_A && b <= CH_UPPER_Z)
                kw_table[pos * 256 + (b + CASE_GAP)] |= bits;
        end
    endtask

    task automatic settle(input logic [1:0] st, input int id, input int len, input logic last);
        out_item_t o;
        if (last)
            restart_match();
        else
            match_done = 1'b1;
        o.status       = st;
        o.keyword_id   = 5'(id);
        o.match_length = 7'(len);
        expected_outcomes.push_back(o);
    endtask

    task automatic settle_best(input logic [1:0] fail_status, input logic last);
        if (best_len > 0)
            settle(STATUS_MATCHED, lowest_set(ended), best_len, last);
        else
            settle(fail_status, 0, 0, last);
    endtask

    task automatic compute_outcome(input in_item_t r);
        logic [63:0] entry;
        logic [31:0] cur;
        logic [31:0] ends;
        int          head;
        out_item_t   o;
        case (r.operation)
            OP_CLEAR:
            begin
                foreach (kw_table[i])
                    kw_table[i] = '0;
                restart_match();
                load_pos = 0;
                load_ovf = 1'b0;
            end
            OP_LOAD:
            begin
                if (load_ovf || load_pos >= MAX_LEN)
                begin
                    load_ovf = 1'b1;
                    if (r.last_byte)
                    begin
                        load_pos       = 0;
                        load_ovf       = 1'b0;
                        o.status       = STATUS_TOO_LONG;
                        o.keyword_id   = r.keyword_index;
                        o.match_length = '0;
                        expected_outcomes.push_back(o);
                    end
                end
                else
                begin
                    enter_byte(load_pos, r.byte_value, 64'd1 << r.keyword_index);
                    if (r.last_byte)
                    begin
                        enter_byte(load_pos, r.byte_value, 64'd1 << (32 + r.keyword_index));
                        load_pos = 0;
                        load_ovf = 1'b0;
                    end
                    else
                    begin
                        load_pos++;
                    end
                end
            end
            OP_MATCH:
            begin
                if (match_done)
                begin
                    if (r.last_byte)
                        restart_match();
                end
                else if (match_pos >= MAX_LEN)
                begin
                    settle_best(STATUS_TOO_SHORT, r.last_byte);
                end
                else
                begin
                    entry = kw_table[match_pos * 256 + r.byte_value];
                    cur   = alive & entry[31:0];
                    if (cur == '0)
                    begin
                        settle_best(STATUS_NO_MATCH, r.last_byte);
                    end
                    else
                    begin
                        ends = entry[63:32] & cur;
                        head = lowest_set(cur);
                        if (ends != '0)
                        begin
                            best_len = match_pos + 1;
                            ended    = ends;
                        end
                        if (ends[head])
                        begin
                            settle(STATUS_MATCHED, head, best_len, r.last_byte);
                        end
                        else
                        begin
                            alive = cur;
                            match_pos++;
                            if (r.last_byte || match_pos >= MAX_LEN)
                                settle_best(STATUS_TOO_SHORT, r.last_byte);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // request driver: bursts of random length, random gaps
    always @(posedge clk)
    begin : driver
        queued_req_t nxt;
        logic        took;
        logic        next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                compute_outcome(in_data);
                requests_left--;
            end
            if (!(in_valid && !took))
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (request_queue.size() != 0 &&
                         !(request_queue[0].drain_first && expected_outcomes.size() != 0))
                begin
                    nxt = request_queue.pop_front();
                    in_data <= nxt.req;
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                in_valid <= next_valid;
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    flag_error($sformatf("unexpected result %h", out_data));
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (out_data.status !== want.status)
                        flag_error($sformatf("status %0d, want %0d",
                                             out_data.status, want.status));
                    if (out_data.keyword_id !== want.keyword_id)
                        flag_error($sformatf("keyword_id %0d, want %0d",
                                             out_data.keyword_id, want.keyword_id));
                    if (out_data.match_length !== want.match_length)
                        flag_error($sformatf("match_length %0d, want %0d",
                                             out_data.match_length, want.match_length));
                end
            end
            stall_tick <= stall_tick + 7'd1;
            case (stall_tick[6:5])
                2'd0: out_stall <= 1'b0;
                2'd1: out_stall <= 1'($urandom_range(0, 1));
                2'd2: out_stall <= (stall_tick[2:0] < 3'd5);
                default: out_stall <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    task automatic queue_req(input logic [1:0] op, input logic [7:0] b, input int kw,
                             input logic last);
        queued_req_t q;
        q.req.operation     = op;
        q.req.byte_value    = b;
        q.req.keyword_index = 5'(kw);
        q.req.last_byte     = last;
        q.drain_first       = hold_for_drain;
        hold_for_drain      = 1'b0;
        requests_left++;
        queued_total++;
        request_queue.push_back(q);
    endtask

    task automatic write_case_mode(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cs_mode = v;
    endtask

    task automatic wait_quiet();
        while (requests_left != 0 || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        if ($urandom_range(0, 6) == 0)
            return 8'($urandom_range(0, 255));
        b = CH_LOWER_A + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0)
            b = b - CASE_GAP;
        return b;
    endfunction

    initial
    begin
        int         phase;
        int         k;
        int         j;
        int         s;
        int         n_kw;
        int         n_subj;
        int         n_loaded;
        int         id;
        int         tag;
        int         len;
        int         base;
        int         subj_len;
        logic [7:0] b;

        foreach (kw_table[i])
            kw_table[i] = '0;
        restart_match();
        load_pos = 0;
        load_ovf = 1'b0;
        cs_mode  = 1'b1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        write_case_mode(1'b1);

        // directed: extremes, every operation, too long, early decision
        queue_req(OP_CLEAR, 8'h00, 0, 1'b0);
        queue_req(OP_LOAD, CH_LOWER_A, 0, 1'b0);
        queue_req(OP_LOAD, CH_LOWER_A + 8'd1, 0, 1'b1);
        queue_req(OP_LOAD, 8'hff, 31, 1'b0);
        queue_req(OP_LOAD, 8'h00, 31, 1'b1);
        queue_req(OP_LOAD, CH_LOWER_A, 5, 1'b1);
        for (j = 0; j <= MAX_LEN; j++)
            queue_req(OP_LOAD, CH_LOWER_Z, 7, j == MAX_LEN);
        queue_req(OP_MATCH, CH_LOWER_A, 0, 1'b0);
        queue_req(OP_MATCH, CH_LOWER_A + 8'd1, 0, 1'b1);
        queue_req(OP_MATCH, CH_LOWER_Z - 8'd2, 0, 1'b1);
        queue_req(OP_MATCH, 8'hff, 0, 1'b1);
        queue_req(OP_NONE, 8'hff, 31, 1'b1);
        queue_req(OP_MATCH, CH_LOWER_A, 0, 1'b0);
        queue_req(OP_MATCH, CH_LOWER_Z, 0, 1'b0);
        queue_req(OP_MATCH, CH_LOWER_Z - 8'd9, 0, 1'b0);
        queue_req(OP_MATCH, CH_LOWER_Z - 8'd9, 0, 1'b1);

        for (phase = 0; queued_total < ITEMS + DIRECTED; phase++)
        begin
            wait_quiet();
            write_case_mode(phase % 2 == 1);

            queue_req(OP_CLEAR, 8'($urandom_range(0, 255)), $urandom_range(0, 31), 1'b0);
            for (k = 0; k < 32; k++)
                kw_len[k] = 0;
            n_loaded = 0;
            n_kw = (phase == 2) ? 32 : $urandom_range(1, 10);
            for (k = 0; k < n_kw; k++)
            begin
                id  = (phase == 2) ? k : $urandom_range(0, 31);
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(MAX_LEN + 1, MAX_LEN + 3)
                                                   : $urandom_range(1, MAX_LEN);
                for (j = 0; j < len; j++)
                begin
                    b = pick_byte();
                    kw_text[id][j] = b;
                    tag = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : id;
                    queue_req(OP_LOAD, b, tag, j == len - 1);
                end
                if (len <= MAX_LEN)
                begin
                    if (kw_len[id] == 0)
                    begin
                        loaded_ids[n_loaded] = id;
                        n_loaded++;
                    end
                    kw_len[id] = len;
                end
            end

            n_subj = $urandom_range(30, 50);
            for (s = 0; s < n_subj && queued_total < ITEMS + DIRECTED; s++)
            begin
                case ($urandom_range(0, 99))
                    0, 1, 2: queue_req(OP_NONE, 8'($urandom_range(0, 255)),
                                       $urandom_range(0, 31), 1'($urandom_range(0, 1)));
                    3, 4: queue_req(OP_LOAD, pick_byte(), $urandom_range(0, 31),
                                    1'($urandom_range(0, 1)));
                    5: queue_req(OP_CLEAR, 8'h00, 0, 1'b0);
                    default:
                    begin
                    end
                endcase
                if (s == 0 || $urandom_range(0, 24) == 0)
                    hold_for_drain = 1'b1;
                if (n_loaded > 0 && $urandom_range(0, 4) != 0)
                begin
                    id   = loaded_ids[$urandom_range(0, n_loaded - 1)];
                    base = kw_len[id];
                    case ($urandom_range(0, 3))
                        0: subj_len = base;
                        1: subj_len = $urandom_range(1, base);
                        default: subj_len = base + $urandom_range(1, 3);
                    endcase
                end
                else
                begin
                    base     = 0;
                    subj_len = $urandom_range(1, MAX_LEN + 3);
                end
                for (j = 0; j < subj_len; j++)
                begin
                    b = (j < base) ? kw_text[id][j] : pick_byte();
                    if ($urandom_range(0, 7) == 0 &&
                        ((b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
                         (b >= CH_UPPER_A && b <= CH_UPPER_Z)))
                        b = b ^ CASE_GAP;
                    if ($urandom_range(0, 15) == 0)
                        b = 8'($urandom_range(0, 255));
                    queue_req(OP_MATCH, b, $urandom_range(0, 31),
                              j == subj_len - 1 && $urandom_range(0, 9) != 0);
                end
            end
        end

        wait_quiet();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
